/* hw/rtl/mba_pkg.sv */
// Shared constants and register codes for the mosaic block averager.
`default_nettype none
package mba_pkg;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_MAX_BLOCK  = 64;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned DIM_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] RST_MOSAIC_SIZE  = 7'd8;
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd1024;
endpackage
`default_nettype wire

/* hw/rtl/mba_if.sv */
// Channel interfaces: pixel input, block result output, config write.
`default_nettype none
interface mba_pix_if import mba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface mba_blk_if import mba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] block_column;
  logic [COORD_W-1:0] block_row;
  logic [PIX_W-1:0]   average_red;
  logic [PIX_W-1:0]   average_green;
  logic [PIX_W-1:0]   average_blue;
  logic               frame_last;
  modport source (output valid, block_column, block_row, average_red, average_green,
                  average_blue, frame_last, input ready);
  modport sink (input valid, block_column, block_row, average_red, average_green,
                average_blue, frame_last, output ready);
endinterface

interface mba_cfg_if import mba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/mba_fifo.sv */
// Two-entry request queue between the front and back ends.
`default_nettype none
module mba_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/mba_front.sv */
// Front end: config registers, raster position tracking, request build.
`default_nettype none
module mba_front import mba_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_BLOCK  = DEF_MAX_BLOCK,
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT),
  localparam int unsigned OW    = $clog2(MAX_BLOCK),
  localparam int unsigned REQ_W = CW + RW + 3 + 3 * PIX_W
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mba_pix_if.sink          pixel,
  mba_cfg_if.sink          cfg,
  output logic             push,
  output logic [REQ_W-1:0] push_data,
  input  wire logic        full
);
  typedef struct packed {
    logic [CW-1:0]    bc;
    logic [RW-1:0]    band;
    logic             first;
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } req_t;

  logic [SIZE_W-1:0] mosaic_size;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [OW-1:0] offset;
  logic [CW-1:0] bcol;
  logic [OW-1:0] rib;
  logic [RW-1:0] band;

  logic [31:0] size_eff;
  logic [31:0] w_eff;
  logic [31:0] h_eff;
  logic        row_end;
  logic        frame_end;
  logic        off_end;
  logic        rib_end;
  logic        accept;
  logic        cfg_hit;
  req_t        req;

  // zero acts as one, oversized values saturate at the build limits
  assign size_eff = (mosaic_size == '0) ? 32'd1 :
                    (32'(mosaic_size) > MAX_BLOCK) ? MAX_BLOCK : 32'(mosaic_size);
  assign w_eff    = (image_width == '0) ? 32'd1 :
                    (32'(image_width) > MAX_WIDTH) ? MAX_WIDTH : 32'(image_width);
  assign h_eff    = (image_height == '0) ? 32'd1 :
                    (32'(image_height) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(image_height);

  assign row_end   = (32'(col) + 32'd1 >= w_eff);
  assign frame_end = (32'(row) + 32'd1 >= h_eff);
  assign off_end   = (32'(offset) + 32'd1 >= size_eff);
  assign rib_end   = (32'(rib) + 32'd1 >= size_eff);

  assign pixel.ready = !full;
  assign cfg.ready   = 1'b1;
  assign accept      = pixel.valid && !full;
  assign cfg_hit     = cfg.valid && (cfg.addr == REG_MOSAIC_SIZE ||
                       cfg.addr == REG_IMAGE_WIDTH || cfg.addr == REG_IMAGE_HEIGHT);

  always_comb begin
    req.bc    = bcol;
    req.band  = band;
    req.first = (rib == '0) && (offset == '0);
    req.emit  = (off_end || row_end) && (rib_end || frame_end);
    req.last  = row_end && frame_end;
    req.r     = pixel.pixel_red;
    req.g     = pixel.pixel_green;
    req.b     = pixel.pixel_blue;
  end

  assign push      = accept;
  assign push_data = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      mosaic_size  <= RST_MOSAIC_SIZE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_MOSAIC_SIZE:  mosaic_size  <= cfg.data[SIZE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (accept && row_end && frame_end)) begin
      col    <= '0;
      row    <= '0;
      offset <= '0;
      bcol   <= '0;
      rib    <= '0;
      band   <= '0;
    end else if (accept) begin
      if (row_end) begin
        col    <= '0;
        offset <= '0;
        bcol   <= '0;
        row    <= row + 1'b1;
        if (rib_end) begin
          rib  <= '0;
          band <= band + 1'b1;
        end else begin
          rib <= rib + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
        if (off_end) begin
          offset <= '0;
          bcol   <= bcol + 1'b1;
        end else begin
          offset <= offset + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/mba_back.sv */
// Back end: column accumulator update, averaging divider, result register.
`default_nettype none
module mba_back import mba_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_BLOCK  = DEF_MAX_BLOCK,
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT),
  localparam int unsigned REQ_W = CW + RW + 3 + 3 * PIX_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [REQ_W-1:0] pop_data,
  input  wire logic             empty,
  output logic                  pop,
  mba_blk_if.source             block
);
  localparam int unsigned SUM_W = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned ENT_W = CNT_W + 3 * SUM_W;
  localparam int unsigned DIV_W = SUM_W + PIX_W;

  typedef struct packed {
    logic [CW-1:0]    bc;
    logic [RW-1:0]    band;
    logic             first;
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] rs;
    logic [SUM_W-1:0] gs;
    logic [SUM_W-1:0] bs;
  } acc_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_OUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  req_t       head;
  req_t       cur;
  acc_t       rd_ent;
  acc_t       new_ent;
  logic [ENT_W-1:0] rd_raw;

  logic [SUM_W-1:0] rem_r, rem_g, rem_b;
  logic [CNT_W-1:0] div_cnt;
  logic [2:0]       step;
  logic [PIX_W-1:0] q_r, q_g, q_b;
  logic [DIV_W-1:0] trial;

  assign head   = pop_data;
  assign rd_ent = rd_raw;
  assign pop    = (state == S_IDLE) && !empty;

  always_comb begin
    if (cur.first) begin
      new_ent.cnt = CNT_W'(1);
      new_ent.rs  = SUM_W'(cur.r);
      new_ent.gs  = SUM_W'(cur.g);
      new_ent.bs  = SUM_W'(cur.b);
    end else begin
      new_ent.cnt = rd_ent.cnt + 1'b1;
      new_ent.rs  = rd_ent.rs + SUM_W'(cur.r);
      new_ent.gs  = rd_ent.gs + SUM_W'(cur.g);
      new_ent.bs  = rd_ent.bs + SUM_W'(cur.b);
    end
  end

  mba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk     (clk),
    .wr_en   (state == S_ACC),
    .wr_addr (cur.bc),
    .wr_data (new_ent),
    .rd_addr (head.bc),
    .rd_data (rd_raw)
  );

  // restoring divide, one quotient bit per cycle for all three channels
  assign trial = DIV_W'(div_cnt) << step;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!empty) state_next = S_ACC;
      S_ACC:  state_next = cur.emit ? S_DIV : S_IDLE;
      S_DIV:  if (step == '0) state_next = S_OUT;
      S_OUT:  if (block.ready) state_next = S_IDLE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!empty) begin
          cur <= head;
        end
      end
      S_ACC: begin
        rem_r   <= new_ent.rs;
        rem_g   <= new_ent.gs;
        rem_b   <= new_ent.bs;
        div_cnt <= new_ent.cnt;
        step    <= 3'd7;
      end
      S_DIV: begin
        if (DIV_W'(rem_r) >= trial) begin
          rem_r       <= rem_r - SUM_W'(trial);
          q_r[step]   <= 1'b1;
        end else begin
          q_r[step]   <= 1'b0;
        end
        if (DIV_W'(rem_g) >= trial) begin
          rem_g       <= rem_g - SUM_W'(trial);
          q_g[step]   <= 1'b1;
        end else begin
          q_g[step]   <= 1'b0;
        end
        if (DIV_W'(rem_b) >= trial) begin
          rem_b       <= rem_b - SUM_W'(trial);
          q_b[step]   <= 1'b1;
        end else begin
          q_b[step]   <= 1'b0;
        end
        step <= step - 1'b1;
      end
      default: ;
    endcase
  end

  assign block.valid         = (state == S_OUT);
  assign block.block_column  = COORD_W'(cur.bc);
  assign block.block_row     = COORD_W'(cur.band);
  assign block.average_red   = q_r;
  assign block.average_green = q_g;
  assign block.average_blue  = q_b;
  assign block.frame_last    = cur.last;
endmodule
`default_nettype wire

/* hw/rtl/mosaic_block_average.sv */
// Top level of the mosaic block averager.
// Pixels come in raster order on the pixel channel and one result per finished
// block leaves on the block channel with the block's coordinates and floor means.
// The front end tracks position and classifies each pixel; a two-entry queue feeds
// the back end, which reads then writes the per-block-column accumulator RAM in
// its IDLE and ACC states, taking no new pixel until back in IDLE; a pixel closing
// a block then runs the shared one-bit-per-cycle divider and waits until taken.
// The accumulator RAM needs no clearing: the first pixel of a block overwrites its
// entry. Any write to a known register restarts the frame; write config only while
// the block is idle.
`default_nettype none
module mosaic_block_average import mba_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_BLOCK  = DEF_MAX_BLOCK
) (
  input wire logic clk,
  input wire logic rst,
  mba_pix_if.sink   pixel,
  mba_cfg_if.sink   cfg,
  mba_blk_if.source block
);
  localparam int unsigned REQ_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 3 + 3 * PIX_W;

  logic             push;
  logic [REQ_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [REQ_W-1:0] pop_data;
  logic             empty;

  mba_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  mba_fifo #(.WIDTH(REQ_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mba_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .block    (block)
  );
endmodule
`default_nettype wire
